/* hw/rtl/qsi_pkg.sv */
// shared types and constants of the quantized state integrator
package qsi_pkg;

	localparam int QSI_WORD_BITS = 48;
	localparam int QSI_FRAC_BITS = 16;

	// command codes of an input beat
	typedef enum logic [1:0] {
		CMD_START   = 2'd0,
		CMD_SLOPE   = 2'd1,
		CMD_ADVANCE = 2'd2
	} qsi_cmd_t;

	// controller states
	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_MUL,
		S_APPLY,
		S_NUM,
		S_DVINIT,
		S_DIV,
		S_DVEND,
		S_FINISH
	} qsi_state_t;

	// commands from controller to datapath and output stage
	typedef struct packed {
		logic idle;
		logic accept;
		logic decode;
		logic mul_step;
		logic apply;
		logic num;
		logic div_init;
		logic set_never;
		logic div_step;
		logic div_done;
		logic out_load;
	} qsi_ctl_t;

	// status from datapath to controller
	typedef struct packed {
		logic [1:0] cmd;
		logic       den_zero;
	} qsi_sts_t;

endpackage

/* hw/rtl/qsi_in_if.sv */
// input channel: command, value and elapsed time
interface qsi_in_if import qsi_pkg::*; #(
	parameter int W = QSI_WORD_BITS
) ();
	logic                valid;
	logic                ready;
	logic [1:0]          cmd;
	logic signed [W-1:0] value;
	logic [W-1:0]        elapsed;

	modport source (output valid, cmd, value, elapsed, input ready);
	modport sink (input valid, cmd, value, elapsed, output ready);
endinterface

/* hw/rtl/qsi_out_if.sv */
// output channel: level event and time advance
interface qsi_out_if import qsi_pkg::*; #(
	parameter int W = QSI_WORD_BITS
) ();
	logic                valid;
	logic                ready;
	logic                event_valid;
	logic signed [W-1:0] event_level;
	logic [W-1:0]        time_advance;

	modport source (output valid, event_valid, event_level, time_advance, input ready);
	modport sink (input valid, event_valid, event_level, time_advance, output ready);
endinterface

/* hw/rtl/qsi_ctrl.sv */
// sequencing state machine of the quantized state integrator
module qsi_ctrl import qsi_pkg::*; #(
	parameter int W = QSI_WORD_BITS
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     item_valid,
	input  logic     out_free,
	input  qsi_sts_t sts,
	output qsi_ctl_t ctl
);
	localparam int CW = (W > 1) ? $clog2(W) : 1;

	qsi_state_t    state_q, state_nx;
	logic [CW-1:0] cnt_q;
	logic          last;

	assign last = (cnt_q == CW'(W - 1));

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// step counter shared by multiply and divide
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.decode || ctl.div_init) begin
			cnt_q <= '0;
		end else if (ctl.mul_step || ctl.div_step) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// next state and commands
	always_comb begin
		state_nx = state_q;
		ctl = '0;
		unique case (state_q)
			S_IDLE: begin
				ctl.idle = 1'b1;
				if (item_valid) begin
					ctl.accept = 1'b1;
					state_nx = S_DECODE;
				end
			end
			S_DECODE: begin
				ctl.decode = 1'b1;
				unique case (sts.cmd) inside
					CMD_SLOPE, CMD_ADVANCE: state_nx = S_MUL;
					default:                state_nx = S_FINISH;
				endcase
			end
			S_MUL: begin
				ctl.mul_step = 1'b1;
				if (last) begin
					state_nx = S_APPLY;
				end
			end
			S_APPLY: begin
				ctl.apply = 1'b1;
				state_nx = S_NUM;
			end
			S_NUM: begin
				ctl.num = 1'b1;
				state_nx = S_DVINIT;
			end
			S_DVINIT: begin
				if (sts.den_zero) begin
					ctl.set_never = 1'b1;
					state_nx = S_FINISH;
				end else begin
					ctl.div_init = 1'b1;
					state_nx = S_DIV;
				end
			end
			S_DIV: begin
				ctl.div_step = 1'b1;
				if (last) begin
					state_nx = S_DVEND;
				end
			end
			S_DVEND: begin
				ctl.div_done = 1'b1;
				state_nx = S_FINISH;
			end
			S_FINISH: begin
				if (out_free) begin
					ctl.out_load = 1'b1;
					state_nx = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

endmodule

/* hw/rtl/qsi_dp.sv */
// datapath: integrator state, serial multiplier and serial divider
module qsi_dp import qsi_pkg::*; #(
	parameter int W = QSI_WORD_BITS,
	parameter int F = QSI_FRAC_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  qsi_ctl_t            ctl,
	input  logic [1:0]          item_cmd,
	input  logic signed [W-1:0] item_value,
	input  logic [W-1:0]        item_elapsed,
	output qsi_sts_t            sts,
	output logic                res_event_valid,
	output logic signed [W-1:0] res_event_level,
	output logic [W-1:0]        res_time_advance
);
	localparam int NW = W + F + 1;
	localparam logic [W-1:0] SMAX_U  = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] SMIN_U  = {1'b1, {(W-1){1'b0}}};
	localparam logic [W-1:0] ONE_U   = {{(W-F-1){1'b0}}, 1'b1, {F{1'b0}}};
	localparam logic [W-1:0] QUANT_U = {{(W-F-2){1'b0}}, 2'b10, {F{1'b0}}};
	localparam logic [W-1:0] FMASK_U = {{(W-F){1'b0}}, {F{1'b1}}};

	// saturate a sum one bit wider than the word
	function automatic logic signed [W-1:0] sat1(input logic signed [W:0] x);
		if (x[W] != x[W-1]) begin
			return x[W] ? $signed(SMIN_U) : $signed(SMAX_U);
		end
		return x[W-1:0];
	endfunction

	// magnitude of a signed word, the lowest value included
	function automatic logic [W-1:0] magw(input logic signed [W-1:0] x);
		return x[W-1] ? (~x + 1'b1) : x;
	endfunction

	// latched beat
	logic [1:0]          cmd_q;
	logic signed [W-1:0] v_q;
	logic [W-1:0]        el_q;

	// integrator state
	logic signed [W-1:0] state_q, level_q, slope_q;
	logic [W-1:0]        adv_q;
	logic                evv_q;
	logic signed [W-1:0] ev_q;

	// multiplier and divider registers
	logic [2*W-1:0]      mp_q;
	logic [W-1:0]        ma_q;
	logic                mneg_q;
	logic [W:0]          num_q;
	logic [W-1:0]        den_q, rem_q, dq_q;
	logic                dsat_q;

	logic signed [W-1:0] fl, start_level, next_level;
	logic signed [W:0]   lvl_step;
	logic [2*W-1:0]      prod_sh;
	logic                big;
	logic [W-1:0]        qmag;
	logic signed [W:0]   st_x, qm_x, acc_sum;
	logic signed [W:0]   sd;
	logic signed [W+1:0] t_sl;
	logic [W:0]          num_nx;
	logic [W-1:0]        den_nx;
	logic [NW-1:0]       nfull;
	logic [F:0]          nhi;
	logic [W:0]          msum;
	logic [W:0]          r2;
	logic                ge;

	assign sts.cmd      = cmd_q;
	assign sts.den_zero = (den_q == '0);

	assign res_event_valid  = evv_q;
	assign res_event_level  = ev_q;
	assign res_time_advance = adv_q;

	// level picked by a start beat: odd integer at or below the value (above it at the most negative floor)
	always_comb begin
		fl = {v_q[W-1:F], {F{1'b0}}};
		if (v_q[F]) begin
			start_level = fl;
		end else if (fl == $signed(SMIN_U)) begin
			start_level = fl + $signed(ONE_U);
		end else begin
			start_level = fl - $signed(ONE_U);
		end
	end

	// next level one quantum in the slope's direction
	always_comb begin
		if (slope_q[W-1]) begin
			lvl_step = {level_q[W-1], level_q} - $signed({1'b0, QUANT_U});
		end else begin
			lvl_step = {level_q[W-1], level_q} + $signed({1'b0, QUANT_U});
		end
		if (slope_q == '0) begin
			next_level = level_q;
		end else begin
			next_level = sat1(lvl_step);
		end
	end

	// scaled product, floored and saturated, added to the state
	always_comb begin
		prod_sh = mp_q >> F;
		big     = |prod_sh[2*W-1:W-1];
		if (big) begin
			qmag = mneg_q ? SMIN_U : SMAX_U;
		end else begin
			qmag = prod_sh[W-1:0];
		end
		st_x = {state_q[W-1], state_q};
		qm_x = $signed({1'b0, qmag});
		acc_sum = mneg_q ? (st_x - qm_x) : (st_x + qm_x);
	end

	// distance to the crossing and divisor
	always_comb begin
		sd = {state_q[W-1], state_q} - {level_q[W-1], level_q};
		if (v_q[W-1]) begin
			t_sl = {sd[W], sd};
		end else begin
			t_sl = $signed({2'b00, QUANT_U}) - {sd[W], sd};
		end
		if (cmd_q == CMD_ADVANCE) begin
			num_nx = {1'b0, QUANT_U};
			den_nx = magw(slope_q);
		end else begin
			num_nx = t_sl[W+1] ? '0 : t_sl[W:0];
			den_nx = magw(v_q);
		end
	end

	// divider set-up and step
	always_comb begin
		nfull = {num_q, {F{1'b0}}};
		nhi   = nfull[W+F:W];
		r2    = {rem_q, dq_q[W-1]};
		ge    = (r2 >= {1'b0, den_q});
	end

	assign msum = {1'b0, mp_q[2*W-1:W]} + {1'b0, ma_q};

	// latch the accepted beat
	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			cmd_q <= item_cmd;
			v_q   <= item_value;
			el_q  <= item_elapsed;
		end
	end

	// integrator state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
			level_q <= $signed(ONE_U);
			slope_q <= '0;
			adv_q   <= '0;
		end else begin
			if (ctl.decode) begin
				case (cmd_q)
					CMD_START: begin
						state_q <= v_q;
						level_q <= start_level;
						slope_q <= '0;
						adv_q   <= '0;
					end
					CMD_ADVANCE: begin
						level_q <= next_level;
					end
					default: begin
					end
				endcase
			end
			if (ctl.apply) begin
				state_q <= sat1(acc_sum);
			end
			if (ctl.num && (cmd_q == CMD_SLOPE)) begin
				slope_q <= v_q;
			end
			if (ctl.set_never) begin
				adv_q <= '1;
			end
			if (ctl.div_done) begin
				adv_q <= dsat_q ? '1 : dq_q;
			end
		end
	end

	// event of the current beat
	always_ff @(posedge clk) begin
		if (ctl.decode) begin
			evv_q <= (cmd_q == CMD_ADVANCE);
			ev_q  <= (cmd_q == CMD_ADVANCE) ? next_level : '0;
		end
	end

	// shift-add multiplier, rounding offset preloaded in the high half
	always_ff @(posedge clk) begin
		if (ctl.decode) begin
			ma_q   <= magw(slope_q);
			mneg_q <= slope_q[W-1];
			mp_q   <= {(slope_q[W-1] ? FMASK_U : '0),
				((cmd_q == CMD_SLOPE) ? el_q : adv_q)};
		end else if (ctl.mul_step) begin
			if (mp_q[0]) begin
				mp_q <= {msum, mp_q[W-1:1]};
			end else begin
				mp_q <= {1'b0, mp_q[2*W-1:W], mp_q[W-1:1]};
			end
		end
	end

	// restoring divider, one quotient bit a cycle
	always_ff @(posedge clk) begin
		if (ctl.num) begin
			num_q <= num_nx;
			den_q <= den_nx;
		end
		if (ctl.div_init) begin
			dsat_q <= (NW'(nhi) >= NW'(den_q));
			rem_q  <= W'(nhi);
			dq_q   <= nfull[W-1:0];
		end else if (ctl.div_step) begin
			rem_q <= ge ? W'(r2 - {1'b0, den_q}) : r2[W-1:0];
			dq_q  <= {dq_q[W-2:0], ge};
		end
	end

endmodule

/* hw/rtl/quantized_state_integrator_core.sv */
// top level of the quantized state integrator
//
// Usage:
//   item channel carries one beat per command: start (load state from value),
//   slope (advance the state by slope times elapsed, take value as the new slope)
//   or time advance (emit the next level and move onto it). Code 3 leaves the
//   state untouched and only reports the current time advance.
//   result channel returns exactly one beat per item: event_valid and
//   event_level for a time advance, and the time until the next internal
//   transition (all ones means never).
// Sequencing:
//   a start beat or code 3 goes from decode straight to the output stage.
//   slope and time advance beats pass the bit-serial multiplier (WORD_BITS
//   steps) and the restoring divider (WORD_BITS steps); a zero divisor skips
//   the divider and reports never.
//   One item is in work at a time; item ready is high only when idle.
// Reset:
//   state 0, level 1.0, slope 0, advance 0, output register empty.
// Stalls:
//   a finished result waits in the output register; the next item may be
//   accepted meanwhile and its result is held back until that beat is taken.
module quantized_state_integrator_core import qsi_pkg::*; #(
	parameter int WORD_BITS = QSI_WORD_BITS,
	parameter int FRAC_BITS = QSI_FRAC_BITS
) (
	input logic        clk,
	input logic        arst_n,
	qsi_in_if.sink     item,
	qsi_out_if.source  result
);
	qsi_ctl_t                    ctl;
	qsi_sts_t                    sts;
	logic                        out_free;
	logic                        res_event_valid;
	logic signed [WORD_BITS-1:0] res_event_level;
	logic [WORD_BITS-1:0]        res_time_advance;

	logic                        ov_q;
	logic                        oev_q;
	logic signed [WORD_BITS-1:0] olevel_q;
	logic [WORD_BITS-1:0]        otime_q;

	assign out_free   = !ov_q || result.ready;
	assign item.ready = ctl.idle;

	// sequencer
	qsi_ctrl #(
		.W (WORD_BITS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.out_free   (out_free),
		.sts        (sts),
		.ctl        (ctl)
	);

	// arithmetic and state
	qsi_dp #(
		.W (WORD_BITS),
		.F (FRAC_BITS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.ctl              (ctl),
		.item_cmd         (item.cmd),
		.item_value       (item.value),
		.item_elapsed     (item.elapsed),
		.sts              (sts),
		.res_event_valid  (res_event_valid),
		.res_event_level  (res_event_level),
		.res_time_advance (res_time_advance)
	);

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (ctl.out_load) begin
			ov_q <= 1'b1;
		end else if (result.ready) begin
			ov_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			oev_q    <= res_event_valid;
			olevel_q <= res_event_level;
			otime_q  <= res_time_advance;
		end
	end

	assign result.valid        = ov_q;
	assign result.event_valid  = oev_q;
	assign result.event_level  = olevel_q;
	assign result.time_advance = otime_q;

	// a result is never loaded over one that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.out_load |-> (!ov_q || result.ready))
		else $error("result loaded over a waiting beat");

	// an accepted item keeps the block busy in the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(item.valid && item.ready) |=> !item.ready)
		else $error("item ready while an item is in work");

	// a loaded result is offered in the next cycle
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.out_load |=> result.valid)
		else $error("loaded result not offered");

	// without an event the level field is zero
	a_quiet_level: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.event_valid) |-> (result.event_level == '0))
		else $error("level set on a beat without event");

endmodule
